// ===== hdl/cls_pkg.sv =====
package cls_pkg;

    localparam int unsigned LOW_SHUNT_W  = 15;
    localparam int unsigned PIN_RES_W    = 11;
    localparam int unsigned HIGH_SHUNT_W = 10;
    localparam int unsigned THRESH_W     = 7;
    localparam int unsigned CFG_DATA_W   = 15;
    localparam int unsigned CFG_INDEX_W  = 2;

    localparam int unsigned SAMPLE_W = 13;
    localparam int unsigned CUR_W    = 29;
    localparam int unsigned NUM_W    = 30;
    localparam int unsigned DEN_W    = 16;

    localparam int unsigned DIV_STEPS = NUM_W;
    localparam int unsigned CNT_W     = 5;

    localparam logic [NUM_W-1:0] K_HIGH   = NUM_W'(100000);
    localparam logic [NUM_W-1:0] K_LOW    = NUM_W'(10000);
    localparam logic [NUM_W-1:0] CUR_MAX  = NUM_W'(500000000);
    localparam logic [SAMPLE_W-1:0] HIGH_DROP_MV = SAMPLE_W'(3);

    localparam logic [LOW_SHUNT_W-1:0]  RST_LOW_SHUNT  = LOW_SHUNT_W'(6800);
    localparam logic [PIN_RES_W-1:0]    RST_PIN_RES    = PIN_RES_W'(200);
    localparam logic [HIGH_SHUNT_W-1:0] RST_HIGH_SHUNT = HIGH_SHUNT_W'(470);
    localparam logic [THRESH_W-1:0]     RST_THRESH     = THRESH_W'(2);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LOW_SHUNT  = 2'd0,
        REG_PIN_RES    = 2'd1,
        REG_HIGH_SHUNT = 2'd2,
        REG_THRESH     = 2'd3
    } t_reg;

    typedef enum logic [1:0] {
        MODE_PIN = 2'd0,
        MODE_HI  = 2'd1,
        MODE_LO  = 2'd2,
        MODE_DIS = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_KEY    = 2'd1,
        CMD_EXIT   = 2'd2,
        CMD_UNUSED = 2'd3
    } t_key;

    typedef struct packed {
        logic [1:0]          command;
        logic [SAMPLE_W-1:0] sample_mv;
    } t_in;

    typedef struct packed {
        logic [1:0]       mode;
        logic             reconfig;
        logic [CUR_W-1:0] current_value;
        logic             current_unit;
        logic             current_valid;
        logic             done_res;
    } t_out;

    typedef struct packed {
        logic capture;
        logic mul;
        logic step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_stat;

endpackage

// ===== hdl/cls_ctrl.sv =====
module cls_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  cls_pkg::t_stat i_stat,
    output cls_pkg::t_cmd  o_cmd
);
    import cls_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_cnt     = '0;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== hdl/cls_dp.sv =====
module cls_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cls_pkg::t_in                      i_in,
    input  logic                              i_cfg_valid,
    input  logic [cls_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [cls_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  cls_pkg::t_cmd                     i_cmd,
    output cls_pkg::t_stat                    o_stat,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output cls_pkg::t_out                     o_out
);
    import cls_pkg::*;

    logic [LOW_SHUNT_W-1:0]  r_low_shunt;
    logic [PIN_RES_W-1:0]    r_pin_res;
    logic [HIGH_SHUNT_W-1:0] r_high_shunt;
    logic [THRESH_W-1:0]     r_thresh;

    t_mode               r_mode;
    t_mode               n_mode;
    logic                n_changed, n_done, n_valid, n_unit, n_hi;
    logic                r_changed, r_done, r_valid, r_unit, r_hi;
    logic [SAMPLE_W-1:0] r_u;
    logic [DEN_W-1:0]    r_den;
    logic [DEN_W-1:0]    r_rem;
    logic [NUM_W-1:0]    r_quo;
    logic [DEN_W:0]      n_trial;
    logic [SAMPLE_W-1:0] w_thresh;
    logic [NUM_W-1:0]    w_sat;
    logic                r_out_valid;
    t_out                r_out;

    assign w_thresh = SAMPLE_W'(r_thresh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_shunt  <= RST_LOW_SHUNT;
            r_pin_res    <= RST_PIN_RES;
            r_high_shunt <= RST_HIGH_SHUNT;
            r_thresh     <= RST_THRESH;
        end else if (i_cfg_valid) begin
            unique case (t_reg'(i_cfg_index))
                REG_LOW_SHUNT:  r_low_shunt  <= i_cfg_data[LOW_SHUNT_W-1:0];
                REG_PIN_RES:    r_pin_res    <= i_cfg_data[PIN_RES_W-1:0];
                REG_HIGH_SHUNT: r_high_shunt <= i_cfg_data[HIGH_SHUNT_W-1:0];
                REG_THRESH:     r_thresh     <= i_cfg_data[THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_mode    = r_mode;
        n_changed = 1'b0;
        n_done    = 1'b0;
        n_valid   = 1'b0;
        n_unit    = 1'b0;
        n_hi      = 1'b0;
        unique case (r_mode)
            MODE_HI: begin
                n_valid = 1'b1;
                n_hi    = 1'b1;
                if (i_in.sample_mv <= HIGH_DROP_MV) begin
                    n_mode    = MODE_LO;
                    n_changed = 1'b1;
                end
            end
            MODE_LO: begin
                if (i_in.sample_mv > w_thresh) begin
                    n_valid = 1'b1;
                    n_unit  = 1'b1;
                end
            end
            MODE_DIS: begin
                if (i_in.sample_mv <= w_thresh) begin
                    n_mode    = MODE_PIN;
                    n_changed = 1'b1;
                end
            end
            default: ;
        endcase
        unique case (t_key'(i_in.command))
            CMD_EXIT: begin
                n_done = 1'b1;
                if (n_mode != MODE_PIN) begin
                    n_changed = 1'b1;
                end
                n_mode = MODE_PIN;
            end
            CMD_KEY: begin
                if (n_mode == MODE_PIN && !n_changed) begin
                    n_mode    = MODE_HI;
                    n_changed = 1'b1;
                end else if (n_mode != MODE_DIS) begin
                    n_mode    = MODE_DIS;
                    n_changed = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_PIN;
        end else if (i_cmd.capture) begin
            r_mode <= n_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_changed <= n_changed;
            r_done    <= n_done;
            r_valid   <= n_valid;
            r_unit    <= n_unit;
            r_hi      <= n_hi;
            r_u       <= i_in.sample_mv;
            r_den     <= n_hi ? (DEN_W'(r_low_shunt) + DEN_W'(r_pin_res))
                              : DEN_W'(r_high_shunt);
        end
    end

    assign n_trial = {r_rem, r_quo[NUM_W-1]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_rem <= '0;
            r_quo <= NUM_W'(r_u) * (r_hi ? K_HIGH : K_LOW);
        end else if (i_cmd.step) begin
            if (n_trial >= {1'b0, r_den}) begin
                r_rem <= DEN_W'(n_trial - {1'b0, r_den});
                r_quo <= {r_quo[NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= n_trial[DEN_W-1:0];
                r_quo <= {r_quo[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign w_sat = (r_den == '0 || r_quo > CUR_MAX) ? CUR_MAX : r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out.mode          <= r_mode;
            r_out.reconfig      <= r_changed;
            r_out.current_value <= r_valid ? w_sat[CUR_W-1:0] : '0;
            r_out.current_unit  <= r_valid & r_unit;
            r_out.current_valid <= r_valid;
            r_out.done_res      <= r_done;
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out           = r_out;

endmodule

// ===== hdl/cap_leakage_sequencer_core.sv =====
// Channel   Direction  Handshake                    Payload
// in        input      i_in_valid / o_in_ready      i_in  (t_in: command, sample_mv)
// out       output     o_out_valid / i_out_ready    o_out (t_out: mode .. done_res)
// cfg       input      i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// One request runs from accept to result as a capture, a multiply, 30 restoring-divider
// steps (one quotient bit per cycle) and a result load.
// A new request is taken once the previous one has reached the output register.
// Reset (i_rst_n low, synchronous) restores register defaults and pinout mode.
// A stalled output holds the result register; the divider then waits before loading.
module cap_leakage_sequencer_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  cls_pkg::t_in                      i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output cls_pkg::t_out                     o_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [cls_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [cls_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import cls_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    cls_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    cls_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule
